@@ hw/rtl/chist_pkg.sv @@
// chist_pkg: shared constants, codes, step table and controller/datapath structs
// for the co-occurrence histogram. No dependencies.
`default_nettype none

package chist_pkg;

    localparam int MAX_MOTIFS = 16;
    localparam int COUNT_BITS = 16;

    // payload field widths
    localparam int OP_W      = 2;
    localparam int ID_W      = 5;
    localparam int SEL_W     = 2;
    localparam int RI_W      = 13;
    localparam int OUT_CNT_W = 16;
    localparam int TOT_W     = 32;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int MC_W       = 5;
    localparam int SC_W       = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTIF_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 1'd1;
    localparam logic [MC_W-1:0]      MOTIF_COUNT_RST = 5'd16;
    localparam logic [SC_W-1:0]      SLOT_COUNT_RST  = 3'd4;

    // operations
    localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // table select
    localparam logic [SEL_W-1:0] TAB_SINGLE  = 2'd0;
    localparam logic [SEL_W-1:0] TAB_PAIR    = 2'd1;
    localparam logic [SEL_W-1:0] TAB_TRIPLET = 2'd2;

    localparam int NUM_SLOTS = 4;

    typedef enum logic [1:0] {
        KIND_SINGLE,
        KIND_PAIR,
        KIND_TRIPLET
    } kind_t;

    // Update steps of one row: 4 singles, 6 pairs, 4 triplets.
    localparam int NUM_STEPS = 14;
    localparam int STEP_W    = $clog2(NUM_STEPS);

    localparam kind_t STEP_KIND [NUM_STEPS] = '{
        KIND_SINGLE, KIND_SINGLE, KIND_SINGLE, KIND_SINGLE,
        KIND_PAIR, KIND_PAIR, KIND_PAIR, KIND_PAIR, KIND_PAIR, KIND_PAIR,
        KIND_TRIPLET, KIND_TRIPLET, KIND_TRIPLET, KIND_TRIPLET
    };
    localparam logic [1:0] STEP_I [NUM_STEPS] = '{
        2'd0, 2'd1, 2'd2, 2'd3, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2,
        2'd0, 2'd0, 2'd0, 2'd1
    };
    localparam logic [1:0] STEP_J [NUM_STEPS] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3,
        2'd1, 2'd1, 2'd2, 2'd2
    };
    localparam logic [1:0] STEP_K [NUM_STEPS] = '{
        2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0,
        2'd2, 2'd3, 2'd3, 2'd3
    };

    typedef struct packed {
        logic load;
        logic calc;
        logic step_next;
        logic rd_en;
        logic wr_en;
        logic rd_req;
        logic take;
        logic flag_bad;
        logic sweep;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            step_active;
        logic            step_last;
        logic            read_bad;
        logic            sweep_last;
    } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/chist_if.sv @@
// chist_in_if / chist_out_if: valid-ready channels for rows in and results out.
// Depends on chist_pkg.
`default_nettype none

interface chist_in_if import chist_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ID_W-1:0]  slot_a;
    logic [ID_W-1:0]  slot_b;
    logic [ID_W-1:0]  slot_c;
    logic [ID_W-1:0]  slot_d;
    logic [SEL_W-1:0] table_select;
    logic [RI_W-1:0]  read_index;

    modport source (
        output valid, operation, slot_a, slot_b, slot_c, slot_d, table_select, read_index,
        input  ready
    );
    modport sink (
        input  valid, operation, slot_a, slot_b, slot_c, slot_d, table_select, read_index,
        output ready
    );
endinterface

interface chist_out_if import chist_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_CNT_W-1:0] count;
    logic [TOT_W-1:0]     single_total;
    logic [TOT_W-1:0]     pair_total;
    logic [TOT_W-1:0]     triplet_total;
    logic                 bad_id;

    modport source (
        output valid, count, single_total, pair_total, triplet_total, bad_id,
        input  ready
    );
    modport sink (
        input  valid, count, single_total, pair_total, triplet_total, bad_id,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/chist_ram.sv @@
// chist_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module chist_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/chist_ctrl.sv @@
// chist_ctrl: sequencer for row updates, reads and clear sweeps; owns the
// channel handshakes. Depends on chist_pkg.
`default_nettype none

module chist_ctrl import chist_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ADDR,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_READ_RD,
        ST_READ_DATA,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   reply_reg, reply_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        reply_next     = reply_reg;
        out_valid_next = out_valid_reg & ~out_ready;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (sts.op)
                    OP_COUNT: state_next = ST_ADDR;
                    OP_READ:  state_next = ST_READ_RD;
                    OP_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                        reply_next = 1'b1;
                    end
                    default:  state_next = ST_DONE;
                endcase
            end
            ST_ADDR:
            begin
                cmd.calc = 1'b1;
                if (sts.step_active)
                begin
                    state_next = ST_RMW_RD;
                end
                else
                begin
                    cmd.step_next = 1'b1;
                    if (sts.step_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RMW_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RMW_WR;
            end
            ST_RMW_WR:
            begin
                cmd.wr_en     = 1'b1;
                cmd.step_next = 1'b1;
                state_next    = sts.step_last ? ST_DONE : ST_ADDR;
            end
            ST_READ_RD:
            begin
                if (sts.read_bad)
                begin
                    cmd.flag_bad = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    cmd.rd_req = 1'b1;
                    state_next = ST_READ_DATA;
                end
            end
            ST_READ_DATA:
            begin
                cmd.take   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    reply_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            reply_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            reply_reg     <= reply_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/chist_dp.sv @@
// chist_dp: configuration registers, row decode, index arithmetic, counter
// memories, running totals and result registers. Depends on chist_pkg, chist_ram.
`default_nettype none

module chist_dp import chist_pkg::*; #(
    parameter int MAX_MOTIFS = chist_pkg::MAX_MOTIFS,
    parameter int COUNT_BITS = chist_pkg::COUNT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [ID_W-1:0]       slot_a,
    input  wire logic [ID_W-1:0]       slot_b,
    input  wire logic [ID_W-1:0]       slot_c,
    input  wire logic [ID_W-1:0]       slot_d,
    input  wire logic [SEL_W-1:0]      table_select,
    input  wire logic [RI_W-1:0]       read_index,
    input  wire cmd_t                  cmd,
    output sts_t                       sts,
    output logic [OUT_CNT_W-1:0]       count,
    output logic [TOT_W-1:0]           single_total,
    output logic [TOT_W-1:0]           pair_total,
    output logic [TOT_W-1:0]           triplet_total,
    output logic                       bad_id
);

    localparam int IDX_W      = $clog2(MAX_MOTIFS);
    localparam int NW         = $clog2(MAX_MOTIFS + 1);
    localparam int PAIR_DEPTH = MAX_MOTIFS * MAX_MOTIFS;
    localparam int TRIP_DEPTH = MAX_MOTIFS * MAX_MOTIFS * MAX_MOTIFS;
    localparam int PA_W       = $clog2(PAIR_DEPTH);
    localparam int TA_W       = $clog2(TRIP_DEPTH);
    localparam int MW         = IDX_W + NW;
    localparam int TW         = PA_W + NW;
    localparam int N2_W       = 2 * NW;
    localparam int N3_W       = 3 * NW;
    localparam int RI0_W      = (TA_W > RI_W) ? TA_W : RI_W;
    localparam int CMP_W      = (N3_W > RI_W) ? N3_W : RI_W;
    localparam int WIDE_W     = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

    // configuration
    logic [MC_W-1:0] motif_reg;
    logic [SC_W-1:0] slot_reg;
    logic [NW-1:0]   n_eff;
    logic [2:0]      ns_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_reg <= MOTIF_COUNT_RST;
            slot_reg  <= SLOT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOTIF_COUNT: motif_reg <= cfg_data[MC_W-1:0];
                CFG_SLOT_COUNT:  slot_reg  <= cfg_data[SC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (motif_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (int'(motif_reg) > MAX_MOTIFS)
        begin
            n_eff = NW'(MAX_MOTIFS);
        end
        else
        begin
            n_eff = NW'(motif_reg);
        end

        if (slot_reg < 3'd2)
        begin
            ns_eff = 3'd2;
        end
        else if (slot_reg > 3'd4)
        begin
            ns_eff = 3'd4;
        end
        else
        begin
            ns_eff = slot_reg;
        end
    end

    // table limits, one multiply per stage
    logic [N2_W-1:0] n2_reg;
    logic [N3_W-1:0] n3_reg;

    always_ff @(posedge clk)
    begin
        n2_reg <= N2_W'(n_eff) * N2_W'(n_eff);
        n3_reg <= N3_W'(n2_reg) * N3_W'(n_eff);
    end

    // row capture
    logic [ID_W-1:0]  slot_in [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] vld_in;
    logic [IDX_W-1:0] id0_in [NUM_SLOTS];
    logic             slot_bad;

    logic [OP_W-1:0]      op_reg;
    logic [SEL_W-1:0]     sel_reg;
    logic [RI_W-1:0]      ri_reg;
    logic [NUM_SLOTS-1:0] vld_reg;
    logic [IDX_W-1:0]     id0_reg [NUM_SLOTS];

    assign slot_in[0] = slot_a;
    assign slot_in[1] = slot_b;
    assign slot_in[2] = slot_c;
    assign slot_in[3] = slot_d;

    always_comb
    begin
        slot_bad = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            id0_in[i] = IDX_W'(slot_in[i] - ID_W'(1));
            vld_in[i] = 1'b0;
            if (3'(i) < ns_eff)
            begin
                if (int'(slot_in[i]) > int'(n_eff))
                begin
                    slot_bad = 1'b1;
                end
                else if (slot_in[i] != '0)
                begin
                    vld_in[i] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            sel_reg <= table_select;
            ri_reg  <= read_index;
            vld_reg <= vld_in;
            id0_reg <= id0_in;
        end
    end

    // step sequencing
    logic [STEP_W-1:0] step_reg;
    kind_t             cur_kind;
    logic [IDX_W-1:0]  id_i, id_j, id_k;
    logic              step_active;
    logic              step_last;

    assign cur_kind  = STEP_KIND[step_reg];
    assign id_i      = id0_reg[STEP_I[step_reg]];
    assign id_j      = id0_reg[STEP_J[step_reg]];
    assign id_k      = id0_reg[STEP_K[step_reg]];
    assign step_last = (step_reg == STEP_W'(NUM_STEPS - 1));

    always_comb
    begin
        step_active = vld_reg[STEP_I[step_reg]];
        if (cur_kind != KIND_SINGLE)
        begin
            step_active = step_active & vld_reg[STEP_J[step_reg]];
        end
        if (cur_kind == KIND_TRIPLET)
        begin
            step_active = step_active & vld_reg[STEP_K[step_reg]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (cmd.load)
        begin
            step_reg <= '0;
        end
        else if (cmd.step_next)
        begin
            step_reg <= step_last ? '0 : step_reg + STEP_W'(1);
        end
    end

    // index arithmetic
    logic [MW-1:0]   m_prod;
    logic [PA_W-1:0] m_reg;
    logic [TW-1:0]   t_prod;
    logic [TA_W-1:0] t_addr;

    assign m_prod = MW'(id_i) * MW'(n_eff) + MW'(id_j);
    assign t_prod = TW'(m_reg) * TW'(n_eff) + TW'(id_k);
    assign t_addr = TA_W'(t_prod);

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            m_reg <= PA_W'(m_prod);
        end
    end

    // read request check
    logic [RI0_W-1:0] ri0;
    logic [CMP_W-1:0] limit;
    logic             read_bad;

    assign ri0 = RI0_W'(ri_reg) - RI0_W'(1);

    always_comb
    begin
        limit    = '0;
        read_bad = 1'b0;
        case (sel_reg)
            TAB_SINGLE:  limit = CMP_W'(n_eff);
            TAB_PAIR:    limit = CMP_W'(n2_reg);
            TAB_TRIPLET: limit = CMP_W'(n3_reg);
            default:     read_bad = 1'b1;
        endcase
        if (ri_reg == '0 || CMP_W'(ri_reg) > limit)
        begin
            read_bad = 1'b1;
        end
    end

    // clear sweep
    logic [TA_W-1:0] sweep_reg;
    logic            sweep_last;

    assign sweep_last = (sweep_reg == TA_W'(TRIP_DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            sweep_reg <= sweep_last ? '0 : sweep_reg + TA_W'(1);
        end
    end

    // counter memories
    logic [IDX_W-1:0]      s_addr;
    logic [PA_W-1:0]       p_addr;
    logic [TA_W-1:0]       x_addr;
    logic [COUNT_BITS-1:0] s_rdata, p_rdata, x_rdata;
    logic [COUNT_BITS-1:0] s_wdata, p_wdata, x_wdata;
    logic                  s_we, p_we, x_we;
    logic                  s_re, p_re, x_re;

    always_comb
    begin
        if (cmd.sweep)
        begin
            s_addr = sweep_reg[IDX_W-1:0];
            p_addr = sweep_reg[PA_W-1:0];
            x_addr = sweep_reg;
        end
        else if (cmd.rd_req)
        begin
            s_addr = ri0[IDX_W-1:0];
            p_addr = ri0[PA_W-1:0];
            x_addr = ri0[TA_W-1:0];
        end
        else
        begin
            s_addr = id_i;
            p_addr = m_reg;
            x_addr = t_addr;
        end
    end

    assign s_wdata = cmd.sweep ? '0 : ((s_rdata == '1) ? s_rdata : s_rdata + COUNT_BITS'(1));
    assign p_wdata = cmd.sweep ? '0 : ((p_rdata == '1) ? p_rdata : p_rdata + COUNT_BITS'(1));
    assign x_wdata = cmd.sweep ? '0 : ((x_rdata == '1) ? x_rdata : x_rdata + COUNT_BITS'(1));

    assign s_we = (cmd.sweep && int'(sweep_reg) < MAX_MOTIFS)
                  || (cmd.wr_en && cur_kind == KIND_SINGLE);
    assign p_we = (cmd.sweep && int'(sweep_reg) < PAIR_DEPTH)
                  || (cmd.wr_en && cur_kind == KIND_PAIR);
    assign x_we = cmd.sweep || (cmd.wr_en && cur_kind == KIND_TRIPLET);

    assign s_re = cmd.rd_req || (cmd.rd_en && cur_kind == KIND_SINGLE);
    assign p_re = cmd.rd_req || (cmd.rd_en && cur_kind == KIND_PAIR);
    assign x_re = cmd.rd_req || (cmd.rd_en && cur_kind == KIND_TRIPLET);

    chist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_MOTIFS)
    ) u_single_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_addr),
        .wdata (s_wdata),
        .re    (s_re),
        .raddr (s_addr),
        .rdata (s_rdata)
    );

    chist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (PAIR_DEPTH)
    ) u_pair_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_addr),
        .wdata (p_wdata),
        .re    (p_re),
        .raddr (p_addr),
        .rdata (p_rdata)
    );

    chist_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TRIP_DEPTH)
    ) u_triplet_ram (
        .clk   (clk),
        .we    (x_we),
        .waddr (x_addr),
        .wdata (x_wdata),
        .re    (x_re),
        .raddr (x_addr),
        .rdata (x_rdata)
    );

    // running totals
    logic [TOT_W-1:0] s_sum_reg, p_sum_reg, x_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_sum_reg <= '0;
            p_sum_reg <= '0;
            x_sum_reg <= '0;
        end
        else if (cmd.sweep)
        begin
            s_sum_reg <= '0;
            p_sum_reg <= '0;
            x_sum_reg <= '0;
        end
        else if (cmd.wr_en)
        begin
            case (cur_kind)
                KIND_SINGLE:
                begin
                    if (s_sum_reg != '1)
                    begin
                        s_sum_reg <= s_sum_reg + TOT_W'(1);
                    end
                end
                KIND_PAIR:
                begin
                    if (p_sum_reg != '1)
                    begin
                        p_sum_reg <= p_sum_reg + TOT_W'(1);
                    end
                end
                KIND_TRIPLET:
                begin
                    if (x_sum_reg != '1)
                    begin
                        x_sum_reg <= x_sum_reg + TOT_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // read data and result
    logic [COUNT_BITS-1:0] sel_data;
    logic [WIDE_W-1:0]     sel_wide;
    logic [OUT_CNT_W-1:0]  sel_sat;
    logic [OUT_CNT_W-1:0]  count_reg;
    logic                  bad_reg;

    always_comb
    begin
        case (sel_reg)
            TAB_SINGLE: sel_data = s_rdata;
            TAB_PAIR:   sel_data = p_rdata;
            default:    sel_data = x_rdata;
        endcase
        sel_wide = WIDE_W'(sel_data);
        sel_sat  = (sel_wide > WIDE_W'({OUT_CNT_W{1'b1}})) ? {OUT_CNT_W{1'b1}}
                                                            : sel_wide[OUT_CNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            count_reg <= '0;
            bad_reg   <= (operation == OP_COUNT) && slot_bad;
        end
        else
        begin
            if (cmd.take)
            begin
                count_reg <= sel_sat;
            end
            if (cmd.flag_bad)
            begin
                bad_reg <= 1'b1;
            end
        end

        if (cmd.emit)
        begin
            count         <= count_reg;
            bad_id        <= bad_reg;
            single_total  <= s_sum_reg;
            pair_total    <= p_sum_reg;
            triplet_total <= x_sum_reg;
        end
    end

    assign sts.op          = op_reg;
    assign sts.step_active = step_active;
    assign sts.step_last   = step_last;
    assign sts.read_bad    = read_bad;
    assign sts.sweep_last  = sweep_last;

endmodule

`default_nettype wire

@@ hw/rtl/cooccurrence_histogram_top.sv @@
// Co-occurrence histogram: single, pair and triplet counters over rows of up to
// four item ids, with a read and a clear operation. A row is accepted and
// decoded, then each of the 14 slot combinations (4 singles, 6 pairs, 4
// triplets) takes an address step, and each combination that is present also
// gets a counter read and a counter write-back on the single-port counter
// memory of its kind, before the result is handed over. A read checks the
// request against the table bounds and skips the counter access when it is out
// of range. A clear sweeps every counter address, MAX_MOTIFS**3 of them (4096 by
// default), and the same sweep runs after reset with the input not ready. The
// next item is taken while a finished result still waits in the output register.
// Depends on chist_pkg, chist_if, chist_ctrl, chist_dp, chist_ram.
`default_nettype none

module cooccurrence_histogram_top import chist_pkg::*; #(
    parameter int MAX_MOTIFS = chist_pkg::MAX_MOTIFS,
    parameter int COUNT_BITS = chist_pkg::COUNT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    chist_in_if.sink                   row,
    chist_out_if.source                result
);

    cmd_t cmd;
    sts_t sts;

    chist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (row.valid),
        .in_ready  (row.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    chist_dp #(
        .MAX_MOTIFS (MAX_MOTIFS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (row.operation),
        .slot_a        (row.slot_a),
        .slot_b        (row.slot_b),
        .slot_c        (row.slot_c),
        .slot_d        (row.slot_d),
        .table_select  (row.table_select),
        .read_index    (row.read_index),
        .cmd           (cmd),
        .sts           (sts),
        .count         (result.count),
        .single_total  (result.single_total),
        .pair_total    (result.pair_total),
        .triplet_total (result.triplet_total),
        .bad_id        (result.bad_id)
    );

endmodule

`default_nettype wire

@@ bench/cooccurrence_histogram_top_tb.sv @@
// Self-checking bench for cooccurrence_histogram_top: drives rows over the valid-ready
// channels, predicts counters and totals in a scoreboard class and checks every result.
// Depends on chist_pkg, chist_if and the RTL of the block.
`timescale 1ns / 1ps

module cooccurrence_histogram_top_tb import chist_pkg::*; ();

    localparam int PAIR_DEPTH = MAX_MOTIFS * MAX_MOTIFS;
    localparam int TRIP_DEPTH = MAX_MOTIFS * MAX_MOTIFS * MAX_MOTIFS;
    localparam logic [OP_W-1:0]  OP_NONE  = 2'd3;
    localparam logic [SEL_W-1:0] TAB_NONE = 2'd3;
    localparam int NUM_PHASES = 10;
    localparam int ROWS_PER_PHASE = 150;
    localparam int unsigned PHASE_MOTIFS [NUM_PHASES] = '{16, 0, 31, 3, 1, 16, 5, 2, 8, 16};
    localparam int unsigned PHASE_SLOTS  [NUM_PHASES] = '{4, 0, 7, 3, 2, 2, 5, 1, 4, 3};

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [3:0][ID_W-1:0]      slot;
        logic [SEL_W-1:0]          sel;
        logic [RI_W-1:0]           ri;
    } hist_row_t;

    typedef struct packed {
        logic [OUT_CNT_W-1:0] count;
        logic [TOT_W-1:0]     single_total;
        logic [TOT_W-1:0]     pair_total;
        logic [TOT_W-1:0]     triplet_total;
        logic                 bad_id;
    } hist_result_t;

    class histogram_scoreboard;
        logic [COUNT_BITS-1:0] single_cnt [MAX_MOTIFS];
        logic [COUNT_BITS-1:0] pair_cnt [PAIR_DEPTH];
        logic [COUNT_BITS-1:0] trip_cnt [TRIP_DEPTH];
        logic [TOT_W-1:0]      single_sum;
        logic [TOT_W-1:0]      pair_sum;
        logic [TOT_W-1:0]      triplet_sum;
        logic [MC_W-1:0]       motif_reg;
        logic [SC_W-1:0]       slot_reg;
        hist_result_t          expected_q [$];
        int                    failures;

        function new();
            wipe();
            motif_reg = MOTIF_COUNT_RST;
            slot_reg = SLOT_COUNT_RST;
            failures = 0;
        endfunction

        function void wipe();
            foreach (single_cnt[i]) single_cnt[i] = '0;
            foreach (pair_cnt[i]) pair_cnt[i] = '0;
            foreach (trip_cnt[i]) trip_cnt[i] = '0;
            single_sum = '0;
            pair_sum = '0;
            triplet_sum = '0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_MOTIF_COUNT)
                motif_reg = data[MC_W-1:0];
            else
                slot_reg = data[SC_W-1:0];
        endfunction

        function int unsigned eff_motifs();
            if (motif_reg == 0)
                return 1;
            if (motif_reg > MAX_MOTIFS)
                return MAX_MOTIFS;
            return 32'(motif_reg);
        endfunction

        function void note_row(hist_row_t it);
            int unsigned n, ns, i, j, k, v, pidx, tidx, lim, depth_ri;
            int unsigned ids [4];
            logic [COUNT_BITS-1:0] word;
            hist_result_t want;
            n = eff_motifs();
            ns = (slot_reg < 2) ? 2 : (slot_reg > 4) ? 4 : 32'(slot_reg);
            want = '0;
            case (it.op)
                OP_COUNT:
                begin
                    for (i = 0; i < 4; i++)
                    begin
                        v = 32'(it.slot[i]);
                        if (i >= ns)
                            v = 0;
                        else if (v > n)
                        begin
                            want.bad_id = 1'b1;
                            v = 0;
                        end
                        ids[i] = v;
                    end
                    for (i = 0; i < ns; i++)
                    begin
                        if (ids[i] == 0)
                            continue;
                        if (single_cnt[(ids[i] - 1) % MAX_MOTIFS] != '1)
                            single_cnt[(ids[i] - 1) % MAX_MOTIFS]++;
                        if (single_sum != '1)
                            single_sum++;
                        for (j = i + 1; j < ns; j++)
                        begin
                            if (ids[j] == 0)
                                continue;
                            pidx = (ids[i] - 1) * n + (ids[j] - 1);
                            if (pair_cnt[pidx % PAIR_DEPTH] != '1)
                                pair_cnt[pidx % PAIR_DEPTH]++;
                            if (pair_sum != '1)
                                pair_sum++;
                            if (ns < 3)
                                continue;
                            for (k = j + 1; k < ns; k++)
                            begin
                                if (ids[k] == 0)
                                    continue;
                                tidx = pidx * n + (ids[k] - 1);
                                if (trip_cnt[tidx % TRIP_DEPTH] != '1)
                                    trip_cnt[tidx % TRIP_DEPTH]++;
                                if (triplet_sum != '1)
                                    triplet_sum++;
                            end
                        end
                    end
                end
                OP_READ:
                begin
                    case (it.sel)
                        TAB_SINGLE:  lim = n;
                        TAB_PAIR:    lim = n * n;
                        TAB_TRIPLET: lim = n * n * n;
                        default:     lim = 0;
                    endcase
                    if (it.sel == TAB_NONE || it.ri == 0 || it.ri > lim)
                        want.bad_id = 1'b1;
                    else
                    begin
                        depth_ri = 32'(it.ri) - 1;
                        case (it.sel)
                            TAB_SINGLE: word = single_cnt[depth_ri % MAX_MOTIFS];
                            TAB_PAIR:   word = pair_cnt[depth_ri % PAIR_DEPTH];
                            default:    word = trip_cnt[depth_ri % TRIP_DEPTH];
                        endcase
                        want.count = (word > 'hFFFF) ? '1 : OUT_CNT_W'(word);
                    end
                end
                OP_CLEAR:
                    wipe();
                default:
                    ;
            endcase
            want.single_total = single_sum;
            want.pair_total = pair_sum;
            want.triplet_total = triplet_sum;
            expected_q.push_back(want);
        endfunction

        function void check_result(hist_result_t got);
            hist_result_t want;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: count %0d bad %0b", got.count, got.bad_id);
                return;
            end
            want = expected_q.pop_front();
            if (got.count !== want.count || got.single_total !== want.single_total ||
                got.pair_total !== want.pair_total || got.triplet_total !== want.triplet_total ||
                got.bad_id !== want.bad_id)
            begin
                failures++;
                if (failures <= 10)
                    $display("mismatch (exp/got): count %0d/%0d single %0d/%0d pair %0d/%0d %s",
                             want.count, got.count, want.single_total, got.single_total,
                             want.pair_total, got.pair_total,
                             $sformatf("triplet %0d/%0d bad %0b/%0b", want.triplet_total,
                                       got.triplet_total, want.bad_id, got.bad_id));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic hold_rx;
    int rows_sent = 0;
    int results_seen = 0;
    histogram_scoreboard sb = new();

    chist_in_if  row_if ();
    chist_out_if result_if ();

    cooccurrence_histogram_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .row       (row_if),
        .result    (result_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic hist_row_t make_row(logic [OP_W-1:0] op, int a, int b, int c, int d,
                                           logic [SEL_W-1:0] sel, int ri);
        hist_row_t r;
        r.op = op;
        r.slot[0] = ID_W'(a);
        r.slot[1] = ID_W'(b);
        r.slot[2] = ID_W'(c);
        r.slot[3] = ID_W'(d);
        r.sel = sel;
        r.ri = RI_W'(ri);
        return r;
    endfunction

    // ids lean toward the low end so that reads of pair and triplet counters hit
    function automatic int unsigned pick_id(int unsigned n);
        int unsigned p;
        p = $urandom_range(0, 9);
        case (p)
            0:       return 0;
            1:       return $urandom_range(n + 1, 31);
            2:       return $urandom_range(0, 31);
            3, 4, 5: return $urandom_range(1, (n < 3) ? n : 3);
            default: return $urandom_range(1, n);
        endcase
    endfunction

    function automatic hist_row_t random_row(int unsigned n);
        hist_row_t r;
        int unsigned p, i, m, a, b, c, lim, near;
        p = $urandom_range(0, 99);
        r.op = (p < 70) ? OP_COUNT : (p < 96) ? OP_READ : (p < 98) ? OP_NONE : OP_CLEAR;
        for (i = 0; i < 4; i++)
            r.slot[i] = ID_W'(pick_id(n));
        r.sel = SEL_W'($urandom_range(0, 3));
        r.ri = RI_W'($urandom_range(0, 8191));
        if (r.op == OP_READ)
        begin
            r.sel = ($urandom_range(0, 15) == 0) ? TAB_NONE : SEL_W'($urandom_range(0, 2));
            m = (n < 3) ? n : 3;
            a = $urandom_range(1, m);
            b = $urandom_range(1, m);
            c = $urandom_range(1, m);
            case (r.sel)
                TAB_SINGLE:
                begin
                    lim = n;
                    near = a;
                end
                TAB_PAIR:
                begin
                    lim = n * n;
                    near = (a - 1) * n + b;
                end
                default:
                begin
                    lim = n * n * n;
                    near = ((a - 1) * n + (b - 1)) * n + c;
                end
            endcase
            p = $urandom_range(0, 9);
            if (p == 0)
                r.ri = '0;
            else if (p == 1 || r.sel == TAB_NONE)
                r.ri = RI_W'($urandom_range(0, 8191));
            else if (p < 6)
                r.ri = RI_W'(near);
            else
                r.ri = RI_W'($urandom_range(1, lim));
        end
        return r;
    endfunction

    function automatic int sender_gap(int phase);
        return (phase % 4 == 1) ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_row(hist_row_t it, int gap);
        if (gap > 0)
        begin
            row_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        row_if.valid        <= 1'b1;
        row_if.operation    <= it.op;
        row_if.slot_a       <= it.slot[0];
        row_if.slot_b       <= it.slot[1];
        row_if.slot_c       <= it.slot[2];
        row_if.slot_d       <= it.slot[3];
        row_if.table_select <= it.sel;
        row_if.read_index   <= it.ri;
        @(posedge clk);
        while (row_if.ready !== 1'b1)
            @(posedge clk);
        sb.note_row(it);
        rows_sent++;
    endtask

    task automatic drain_results();
        row_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        hist_row_t directed_q [$];
        int phase;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_MOTIF_COUNT;
        cfg_data            <= '0;
        row_if.valid        <= 1'b0;
        row_if.operation    <= OP_COUNT;
        row_if.slot_a       <= '0;
        row_if.slot_b       <= '0;
        row_if.slot_c       <= '0;
        row_if.slot_d       <= '0;
        row_if.table_select <= TAB_SINGLE;
        row_if.read_index   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_SINGLE, 1));
        directed_q.push_back(make_row(OP_COUNT, 16, 16, 16, 16, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_COUNT, 1, 2, 3, 4, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_COUNT, 0, 0, 0, 0, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_COUNT, 17, 31, 5, 0, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_COUNT, 1, 0, 2, 0, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_SINGLE, 16));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_SINGLE, 17));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_PAIR, 256));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_PAIR, 257));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_TRIPLET, 4096));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_TRIPLET, 4097));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_NONE, 1));
        directed_q.push_back(make_row(OP_READ, 31, 31, 31, 31, TAB_SINGLE, 8191));
        directed_q.push_back(make_row(OP_NONE, 31, 17, 9, 1, TAB_NONE, 8191));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_PAIR, 2));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_TRIPLET, 19));
        directed_q.push_back(make_row(OP_CLEAR, 0, 0, 0, 0, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_PAIR, 256));
        directed_q.push_back(make_row(OP_COUNT, 31, 31, 31, 31, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_COUNT, 16, 1, 16, 1, TAB_SINGLE, 0));
        directed_q.push_back(make_row(OP_READ, 0, 0, 0, 0, TAB_PAIR, 241));

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                drain_results();
                @(posedge clk);
                cfg_we    <= 1'b1;
                cfg_index <= CFG_MOTIF_COUNT;
                cfg_data  <= CFG_DATA_W'(PHASE_MOTIFS[phase]);
                @(posedge clk);
                cfg_index <= CFG_SLOT_COUNT;
                cfg_data  <= CFG_DATA_W'(PHASE_SLOTS[phase]);
                @(posedge clk);
                cfg_we    <= 1'b0;
                sb.write_reg(CFG_MOTIF_COUNT, CFG_DATA_W'(PHASE_MOTIFS[phase]));
                sb.write_reg(CFG_SLOT_COUNT, CFG_DATA_W'(PHASE_SLOTS[phase]));
            end
            else
            begin
                foreach (directed_q[i])
                    send_row(directed_q[i], sender_gap(phase));
            end
            repeat (ROWS_PER_PHASE)
                send_row(random_row(sb.eff_motifs()), sender_gap(phase));
        end

        drain_results();
        repeat (60) @(posedge clk);
        if (sb.failures == 0 && sb.expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall per beat, quiet stretches, plus the long hold
    initial
    begin
        int stall_left;
        hist_result_t got;
        stall_left = 0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_if.valid === 1'b1 && result_if.ready === 1'b1)
            begin
                got.count         = result_if.count;
                got.single_total  = result_if.single_total;
                got.pair_total    = result_if.pair_total;
                got.triplet_total = result_if.triplet_total;
                got.bad_id        = result_if.bad_id;
                sb.check_result(got);
                results_seen++;
                stall_left = ((results_seen / 64) % 4 == 3) ? 0 : $urandom_range(0, 19);
            end
            else if (stall_left > 0)
                stall_left--;
            result_if.ready <= (stall_left == 0) && !hold_rx;
        end
    end

    initial
    begin
        hold_rx <= 1'b0;
        while (rows_sent < 400)
            @(posedge clk);
        hold_rx <= 1'b1;
        repeat (500) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/chist_pkg.sv
hw/rtl/chist_if.sv
hw/rtl/chist_ram.sv
hw/rtl/chist_ctrl.sv
hw/rtl/chist_dp.sv
hw/rtl/cooccurrence_histogram_top.sv
bench/cooccurrence_histogram_top_tb.sv
